// ===== sv/lfu_pkg.sv =====
// Package for the LFU cache with LRU tie-break.
// Holds entry and cell control types, field widths and operation codes.
// No dependencies.
package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  // operation codes carried on func
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // result values that do not come from an entry
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } entry_t;

  // per-cell load strobes
  typedef struct packed {
    logic load_new;
    logic load_prev;
  } cell_ctl_t;

  // per-cell compare results
  typedef struct packed {
    logic eq;
    logic le;
    logic zero;
  } cell_stat_t;

endpackage

// ===== sv/lfu_cell.sv =====
// One list slot of the LFU cache: holds an entry, compares it against the
// broadcast key and count, and loads either the new entry or its neighbor.
// Depends on lfu_pkg.
module lfu_cell (
  input  logic                    clk,
  input  lfu_pkg::cell_ctl_t      ctl,
  input  lfu_pkg::entry_t         new_entry,
  input  lfu_pkg::entry_t         prev_entry,
  input  logic [lfu_pkg::KEY_W-1:0] cmp_key,
  input  logic [lfu_pkg::CNT_W-1:0] cmp_count,
  output lfu_pkg::entry_t         entry,
  output lfu_pkg::cell_stat_t     stat
);
  import lfu_pkg::*;

  // load new entry or shift in from the neighbor above
  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      entry <= new_entry;
    end else if (ctl.load_prev) begin
      entry <= prev_entry;
    end
  end

  // compare against the broadcast request
  always_comb begin
    stat.eq   = (entry.key == cmp_key);
    stat.le   = (entry.count <= cmp_count);
    stat.zero = (entry.count == '0);
  end

endmodule

// ===== sv/lfu_cache_lru_tiebreak_core.sv =====
// Top level of the LFU cache with LRU tie-break: request register, control
// sequencer, occupancy count and the chain of lfu_cell slots.
// Depends on lfu_pkg and lfu_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | func, lookup_key, store_value
//  out     | out_valid / out_ready| hit, read_value
//  cfg     | cfg_valid / cfg_ready| capacity_limit
//
// Each request passes a match state, for the key match across all cells, and a
// move state, for the reorder shift through the chain. A new request is taken
// in the move state once the result slot is free, overlapping the last one.
// The result register holds until out_ready; a held result stalls the shift.
// Reset (synchronous) empties the cache and sets capacity_limit to 16.
module lfu_cache_lru_tiebreak_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             func,
  input  logic signed [lfu_pkg::KEY_W-1:0] lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0] store_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic signed [lfu_pkg::VAL_W-1:0] read_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]        capacity_limit
);
  import lfu_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_MOVE  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CAP_W-1:0] cap_limit;
  logic [CW-1:0]    occ;

  logic             req_func;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  logic                   found;
  logic [VAL_W-1:0]       sel_value;
  logic [CNT_W-1:0]       sel_count;
  logic [MAX_ENTRIES-1:0] at_pos;

  entry_t     entries   [MAX_ENTRIES];
  entry_t     prev_in   [MAX_ENTRIES];
  cell_ctl_t  ctl       [MAX_ENTRIES];
  cell_stat_t stat      [MAX_ENTRIES];

  entry_t                 new_entry;
  logic [CNT_W-1:0]       bumped;
  logic [MAX_ENTRIES-1:0] eq_live;
  logic                   found_next;
  logic [VAL_W-1:0]       sel_value_next;
  logic [CNT_W-1:0]       sel_count_next;
  logic [MAX_ENTRIES-1:0] at_pos_next;
  logic [MAX_ENTRIES-1:0] pred;
  logic [MAX_ENTRIES-1:0] lim;
  logic [CW-1:0]          cap_eff;
  logic [CW-1:0]          occ_drop;
  logic                   adv;
  logic                   do_use;
  logic                   do_ins;

  assign cfg_ready = 1'b1;

  // result slot free or being emptied this cycle
  assign adv      = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) || (state == ST_MOVE && adv);

  // sequence: match, then shift
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        if (adv) state_next = in_valid ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // effective capacity and occupancy after a tail drop
  always_comb begin
    if (LW'(cap_limit) > LW'(MAX_ENTRIES)) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = CW'(cap_limit);
    end
    if (occ >= cap_eff && occ != '0) begin
      occ_drop = occ - CW'(1);
    end else begin
      occ_drop = occ;
    end
  end

  assign do_use = found && ((req_func == FUNC_GET) ||
                            (req_func == FUNC_PUT && cap_limit != '0));
  assign do_ins = !found && req_func == FUNC_PUT && cap_limit != '0;

  // bumped use count, saturating
  assign bumped = (sel_count == CNT_MAX) ? sel_count : sel_count + CNT_W'(1);

  // entry to place at the insert or move target
  always_comb begin
    new_entry.key = req_key;
    if (do_ins) begin
      new_entry.value = req_value;
      new_entry.count = '0;
    end else begin
      new_entry.value = (req_func == FUNC_PUT) ? req_value : sel_value;
      new_entry.count = bumped;
    end
  end

  // match across live cells, select matched value and count
  always_comb begin
    sel_value_next = '0;
    sel_count_next = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      eq_live[j] = stat[j].eq && (CW'(j) < occ);
      if (eq_live[j]) begin
        sel_value_next = sel_value_next | entries[j].value;
        sel_count_next = sel_count_next | entries[j].count;
      end
    end
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      at_pos_next[j] = |(eq_live >> j);
    end
    found_next = |eq_live;
  end

  // target predicate and shift range for each cell
  always_comb begin
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (do_ins) begin
        pred[j] = (CW'(j) >= occ_drop) || stat[j].zero;
        lim[j]  = (CW'(j) <= occ_drop);
      end else begin
        pred[j] = stat[j].le;
        lim[j]  = at_pos[j];
      end
    end
  end

  // load strobes: first cell meeting the predicate takes the new entry,
  // the cells after it up to the limit shift down by one
  always_comb begin
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      ctl[j].load_new  = 1'b0;
      ctl[j].load_prev = 1'b0;
      if (state == ST_MOVE && adv && (do_use || do_ins) && lim[j]) begin
        if (j == 0) begin
          ctl[j].load_new = pred[j];
        end else begin
          ctl[j].load_new  = pred[j] && !pred[j-1];
          ctl[j].load_prev = pred[j-1];
        end
      end
    end
  end

  // cell chain
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_in[g] = new_entry;
    end else begin : g_link
      assign prev_in[g] = entries[g-1];
    end
    lfu_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .new_entry  (new_entry),
      .prev_entry (prev_in[g]),
      .cmp_key    (req_key),
      .cmp_count  (bumped),
      .entry      (entries[g]),
      .stat       (stat[g])
    );
  end

  // control state, occupancy and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      cap_limit <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        cap_limit <= capacity_limit;
      end
      if (state == ST_MOVE && adv) begin
        out_valid <= 1'b1;
        if (do_ins) begin
          occ <= occ_drop + CW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_func  <= func;
      req_key   <= lookup_key;
      req_value <= store_value;
    end
  end

  // hold match results for the shift cycle
  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      found     <= found_next;
      sel_value <= sel_value_next;
      sel_count <= sel_count_next;
      at_pos    <= at_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_MOVE && adv) begin
      hit <= found;
      if (req_func == FUNC_GET) begin
        read_value <= found ? sel_value : MISS_VALUE;
      end else begin
        read_value <= PUT_VALUE;
      end
    end
  end

endmodule

// ===== sv/lfu_checker.sv =====
// Port-level checks for the LFU cache core, attached by bind.
// Depends on lfu_pkg and lfu_cache_lru_tiebreak_core.
module lfu_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             hit,
  input logic signed [lfu_pkg::VAL_W-1:0] read_value
);
  import lfu_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value))
    else $error("result changed while stalled");

  // one request at a time: no request taken right after another
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken during match cycle");

  // a request is followed by a result: loaded as the move state ends, or an
  // older result still held while the move waits
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##3 out_valid)
    else $error("no result after request");

  // a miss reports either the miss value or the put value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == MISS_VALUE || read_value == PUT_VALUE)
    else $error("miss carries an entry value");

endmodule

bind lfu_cache_lru_tiebreak_core lfu_checker u_lfu_checker (.*);
